FILE: rtl/atlb_pkg.sv
package atlb_pkg;

    localparam int SPACE_W = 4;
    localparam int VA_W    = 32;
    localparam int PAGE_W  = 20;
    localparam int OFF_W   = 12;
    localparam int FRAME_W = 20;
    localparam int CH_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int IDX_W   = 8;

    localparam logic [CH_W-1:0] RELOAD_RESET = 3'd2;

    typedef struct packed {
        logic [SPACE_W-1:0] space;
        logic [PAGE_W-1:0]  page;
        logic               wr;
    } t_req;

    typedef struct packed {
        logic               active;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [FRAME_W-1:0] hit_frame;
        logic               inv_found;
        logic [IDX_W-1:0]   inv_idx;
        logic               zero_found;
        logic [IDX_W-1:0]   zero_idx;
    } t_carry;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               replace;
        logic [CH_W-1:0]    reload;
        logic [SPACE_W-1:0] space;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_fill;

endpackage

FILE: rtl/atlb_cell.sv
module atlb_cell
    import atlb_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_req   i_req,
    input  t_fill  i_fill,
    input  t_carry i_carry,
    output t_carry o_carry
);

    logic               r_valid;
    logic [CH_W-1:0]    r_chances;
    logic               r_dirty;
    logic [SPACE_W-1:0] r_space;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    t_carry             r_carry;

    logic               w_same;
    logic               w_match;
    logic               w_fill;
    logic [CH_W-1:0]    w_dec;
    t_carry             n_carry;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    assign w_same  = r_valid && (r_space == i_req.space);
    assign w_match = w_same && (r_page == i_req.page);
    assign w_fill  = i_fill.en && (i_fill.idx == MY_IDX);

    always_comb begin
        w_dec = r_chances;
        if (w_same && !w_match && (r_chances != '0)) begin
            w_dec = r_chances - CH_W'(1);
        end
        n_carry = i_carry;
        if (w_match) begin
            n_carry.hit       = 1'b1;
            n_carry.hit_idx   = MY_IDX;
            n_carry.hit_frame = r_frame;
        end
        if (!i_carry.inv_found && !r_valid) begin
            n_carry.inv_found = 1'b1;
            n_carry.inv_idx   = MY_IDX;
        end
        if (!i_carry.zero_found && (w_dec == '0)) begin
            n_carry.zero_found = 1'b1;
            n_carry.zero_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_chances <= '0;
            r_dirty   <= 1'b0;
            r_carry   <= '0;
        end else begin
            r_carry <= n_carry;
            if (i_carry.active) begin
                r_chances <= w_dec;
                if (w_match && i_req.wr) begin
                    r_dirty <= 1'b1;
                end
            end else if (w_fill) begin
                r_valid <= 1'b1;
                if (i_fill.replace) begin
                    r_chances <= i_fill.reload;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_carry.active && w_fill) begin
            r_space <= i_fill.space;
            r_page  <= i_fill.page;
            r_frame <= i_fill.frame;
        end
    end

    assign o_carry = r_carry;

endmodule

FILE: rtl/asid_tlb_second_chance.sv
// Channel  | Valid       | Stall        | Payload
// ---------+-------------+--------------+----------------------------------------------
// request  | i_in_valid  | o_in_stall   | i_space_id i_virtual_address i_is_write
//          |             |              | i_walk_frame
// result   | o_out_valid | i_out_stall  | o_hit o_frame o_physical_address o_filled o_slot
// config   | i_cfg_we    | -            | i_cfg_wdata (reload_chances)
//
// A lookup walks the cell row one entry per cycle: o_out_valid rises after the walk as the
// result registers, later while an earlier result is still stalled.
// One request is in flight at a time; the next is taken the cycle after the result registers.
// The fill of a missed page is broadcast to the row after the walk, in the
// cycle the result is registered; it waits there while the result is stalled.
// Synchronous reset empties all entries and sets reload_chances to 2.
module asid_tlb_second_chance
    import atlb_pkg::*;
#(
    parameter int TLB_ENTRIES = 32,
    parameter int SPACE_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CH_W-1:0]    i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [SPACE_W-1:0] i_space_id,
    input  logic [VA_W-1:0]    i_virtual_address,
    input  logic               i_is_write,
    input  logic [FRAME_W-1:0] i_walk_frame,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame,
    output logic [VA_W-1:0]    o_physical_address,
    output logic               o_filled,
    output logic [SLOT_W-1:0]  o_slot
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic               r_kick;
    logic [CH_W-1:0]    r_reload;
    t_req               r_req;
    logic [FRAME_W-1:0] r_walk;
    logic [OFF_W-1:0]   r_offset;
    t_carry             r_fin;

    logic               r_out_valid;
    logic               r_hit;
    logic [FRAME_W-1:0] r_frame;
    logic [OFF_W-1:0]   r_out_offset;
    logic               r_filled;
    logic [SLOT_W-1:0]  r_slot;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_finish;
    logic [8:0]         w_space;
    logic [IDX_W-1:0]   w_pick;
    logic               w_can_fill;
    t_fill              w_fill;
    t_carry             w_head;
    t_carry             w_carry [0:TLB_ENTRIES];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    always_comb begin
        w_space = {5'd0, i_space_id};
        for (int k = 0; k < 8; k++) begin
            if (w_space >= 9'(SPACE_COUNT)) begin
                w_space = w_space - 9'(SPACE_COUNT);
            end
        end
    end

    assign w_pick     = r_fin.inv_found ? r_fin.inv_idx : r_fin.zero_idx;
    assign w_can_fill = !r_fin.hit && (r_fin.inv_found || r_fin.zero_found);

    always_comb begin
        w_fill.en      = w_finish && w_can_fill;
        w_fill.idx     = w_pick;
        w_fill.replace = !r_fin.inv_found;
        w_fill.reload  = r_reload;
        w_fill.space   = r_req.space;
        w_fill.page    = r_req.page;
        w_fill.frame   = r_walk;
    end

    always_comb begin
        w_head        = '0;
        w_head.active = r_kick;
    end

    assign w_carry[0] = w_head;

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        atlb_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req),
            .i_fill (w_fill),
            .i_carry(w_carry[g]),
            .o_carry(w_carry[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kick      <= 1'b0;
            r_reload    <= RELOAD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_kick <= w_in_xfer;
            if (i_cfg_we) begin
                r_reload <= i_cfg_wdata;
            end
            if (!w_finish && r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_carry[TLB_ENTRIES].active) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req.space <= w_space[SPACE_W-1:0];
            r_req.page  <= i_virtual_address[VA_W-1:OFF_W];
            r_req.wr    <= i_is_write;
            r_walk      <= i_walk_frame;
            r_offset    <= i_virtual_address[OFF_W-1:0];
        end
        if (w_carry[TLB_ENTRIES].active) begin
            r_fin <= w_carry[TLB_ENTRIES];
        end
        if (w_finish) begin
            r_hit        <= r_fin.hit;
            r_frame      <= r_fin.hit ? r_fin.hit_frame : r_walk;
            r_out_offset <= r_offset;
            r_filled     <= w_can_fill;
            if (r_fin.hit) begin
                r_slot <= r_fin.hit_idx[SLOT_W-1:0];
            end else if (w_can_fill) begin
                r_slot <= w_pick[SLOT_W-1:0];
            end else begin
                r_slot <= '0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_frame            = r_frame;
    assign o_physical_address = {r_frame, r_out_offset};
    assign o_filled           = r_filled;
    assign o_slot             = r_slot;

endmodule

FILE: rtl/atlb_checker.sv
module atlb_sva
    import atlb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_hit,
    input logic [FRAME_W-1:0] o_frame,
    input logic [VA_W-1:0]    o_physical_address,
    input logic               o_filled,
    input logic [SLOT_W-1:0]  o_slot
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_physical_address)
            && $stable(o_slot))
        else $error("stalled result changed");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while a lookup is in flight");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared too soon after request");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_filled
            && (o_physical_address[VA_W-1:OFF_W] == o_frame))
        else $error("hit result inconsistent");

    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit && !o_filled |-> o_slot == '0)
        else $error("slot set without hit or fill");

endmodule

bind asid_tlb_second_chance atlb_sva u_atlb_sva (.*);

FILE: dv/atlb_checker.sv
`timescale 1ns / 1ps
module atlb_checker
    import atlb_pkg::*;
#(
    parameter int TLB_ENTRIES = 32,
    parameter int SPACE_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CH_W-1:0]    i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [SPACE_W-1:0] i_space_id,
    input  logic [VA_W-1:0]    i_virtual_address,
    input  logic               i_is_write,
    input  logic [FRAME_W-1:0] i_walk_frame,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_hit,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [VA_W-1:0]    i_physical_address,
    input  logic               i_filled,
    input  logic [SLOT_W-1:0]  i_slot,
    output int                 o_mismatches,
    output int                 o_pending
);

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [VA_W-1:0]    paddr;
        logic               filled;
        logic [SLOT_W-1:0]  slot;
    } t_xlate;

    logic               tlb_valid   [TLB_ENTRIES];
    logic [SPACE_W-1:0] tlb_space   [TLB_ENTRIES];
    logic [PAGE_W-1:0]  tlb_page    [TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame   [TLB_ENTRIES];
    logic [CH_W-1:0]    tlb_chances [TLB_ENTRIES];
    logic               tlb_dirty   [TLB_ENTRIES];
    logic [CH_W-1:0]    reload_chances;

    t_xlate pending_xlates[$];
    int     mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_xlate translate_access(input logic [SPACE_W-1:0] space_in,
                                                input logic [VA_W-1:0] va,
                                                input logic wr,
                                                input logic [FRAME_W-1:0] walk);
        t_xlate             r;
        int                 pick;
        logic [SPACE_W-1:0] sp;
        logic [PAGE_W-1:0]  pg;
        sp       = SPACE_W'(int'(space_in) % SPACE_COUNT);
        pg       = va[VA_W-1:OFF_W];
        r.hit    = 1'b0;
        r.filled = 1'b0;
        r.slot   = '0;
        r.frame  = walk;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_valid[i] && tlb_space[i] == sp) begin
                if (tlb_page[i] == pg) begin
                    r.hit   = 1'b1;
                    r.slot  = SLOT_W'(i);
                    r.frame = tlb_frame[i];
                    if (wr) tlb_dirty[i] = 1'b1;
                end else if (tlb_chances[i] != '0) begin
                    tlb_chances[i] = tlb_chances[i] - CH_W'(1);
                end
            end
        end
        if (!r.hit) begin
            pick = -1;
            for (int i = 0; i < TLB_ENTRIES && pick < 0; i++)
                if (!tlb_valid[i]) pick = i;
            for (int i = 0; i < TLB_ENTRIES && pick < 0; i++) begin
                if (tlb_chances[i] == '0) begin
                    pick = i;
                    tlb_chances[i] = reload_chances;
                end
            end
            if (pick >= 0) begin
                tlb_valid[pick] = 1'b1;
                tlb_space[pick] = sp;
                tlb_page[pick]  = pg;
                tlb_frame[pick] = walk;
                r.filled        = 1'b1;
                r.slot          = SLOT_W'(pick);
            end
        end
        r.paddr = {r.frame, va[OFF_W-1:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_xlate got;
        t_xlate want;
        if (!i_rst_n) begin
            reload_chances = RELOAD_RESET;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                tlb_valid[i]   = 1'b0;
                tlb_space[i]   = '0;
                tlb_page[i]    = '0;
                tlb_frame[i]   = '0;
                tlb_chances[i] = '0;
                tlb_dirty[i]   = 1'b0;
            end
            pending_xlates.delete();
        end else begin
            if (i_cfg_we) reload_chances = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                got.hit    = i_hit;
                got.frame  = i_frame;
                got.paddr  = i_physical_address;
                got.filled = i_filled;
                got.slot   = i_slot;
                if (pending_xlates.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'({got.slot, got.frame}), 32'(0));
                end else begin
                    want = pending_xlates.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                    if (got.frame !== want.frame)
                        report_mismatch("frame", 32'(got.frame), 32'(want.frame));
                    if (got.paddr !== want.paddr)
                        report_mismatch("physical_address", got.paddr, want.paddr);
                    if (got.filled !== want.filled)
                        report_mismatch("filled", 32'(got.filled), 32'(want.filled));
                    if (got.slot !== want.slot)
                        report_mismatch("slot", 32'(got.slot), 32'(want.slot));
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_xlates.push_back(translate_access(i_space_id, i_virtual_address,
                                                          i_is_write, i_walk_frame));
        end
        o_pending    <= pending_xlates.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import atlb_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 230;
    localparam int PHASES       = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CH_W-1:0]    i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [SPACE_W-1:0] i_space_id;
    logic [VA_W-1:0]    i_virtual_address;
    logic               i_is_write;
    logic [FRAME_W-1:0] i_walk_frame;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame;
    logic [VA_W-1:0]    o_physical_address;
    logic               o_filled;
    logic [SLOT_W-1:0]  o_slot;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int hold_req    = 0;
    int hold_served = 0;
    logic quiet     = 1'b0;

    logic [PAGE_W-1:0]  page_pool  [48];
    logic [SPACE_W-1:0] space_pool [16];
    int page_span;
    int space_span;

    logic [CH_W-1:0] reload_plan [PHASES] = '{3'd0, 3'd7, 3'd1, 3'd7, 3'd4, 3'd3, 3'd6, 3'd2};

    asid_tlb_second_chance uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_space_id         (i_space_id),
        .i_virtual_address  (i_virtual_address),
        .i_is_write         (i_is_write),
        .i_walk_frame       (i_walk_frame),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_frame            (o_frame),
        .o_physical_address (o_physical_address),
        .o_filled           (o_filled),
        .o_slot             (o_slot)
    );

    atlb_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_space_id         (i_space_id),
        .i_virtual_address  (i_virtual_address),
        .i_is_write         (i_is_write),
        .i_walk_frame       (i_walk_frame),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_hit              (o_hit),
        .i_frame            (o_frame),
        .i_physical_address (o_physical_address),
        .i_filled           (o_filled),
        .i_slot             (o_slot),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_req) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic drive_access(input logic [SPACE_W-1:0] sp, input logic [VA_W-1:0] va,
                                input logic wr, input logic [FRAME_W-1:0] walk);
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_space_id        <= sp;
        i_virtual_address <= va;
        i_is_write        <= wr;
        i_walk_frame      <= walk;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic sender_idle(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain_translations();
        sender_idle(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reload(input logic [CH_W-1:0] value);
        drain_translations();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic build_pools(input int spaces, input int pages);
        space_span = spaces;
        page_span  = pages;
        foreach (space_pool[i]) space_pool[i] = SPACE_W'($urandom);
        foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);
        page_pool[0] = '0;
        page_pool[1] = '1;
    endtask

    task automatic random_access();
        logic [SPACE_W-1:0] sp;
        logic [VA_W-1:0]    va;
        if (!quiet && $urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 5));
        if (!quiet && $urandom_range(0, 60) == 0) drain_translations();
        if ($urandom_range(0, 7) == 0) begin
            sp = SPACE_W'($urandom);
            va = $urandom;
        end else begin
            sp = space_pool[$urandom_range(0, space_span - 1)];
            va = {page_pool[$urandom_range(0, page_span - 1)], OFF_W'($urandom)};
        end
        drive_access(sp, va, 1'($urandom), FRAME_W'($urandom));
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_space_id        = '0;
        i_virtual_address = '0;
        i_is_write        = 1'b0;
        i_walk_frame      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_access(4'h0, 32'h0000_0000, 1'b0, 20'h00000);
        drive_access(4'h0, 32'h0000_0000, 1'b0, 20'hFFFFF);
        drive_access(4'hF, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
        drive_access(4'hF, 32'hFFFF_F000, 1'b0, 20'h00000);
        drive_access(4'h0, 32'hFFFF_F123, 1'b1, 20'h12345);
        drive_access(4'hF, 32'h0000_0FFF, 1'b1, 20'hABCDE);
        drive_access(4'h0, 32'h0000_0ABC, 1'b1, 20'h55555);
        drive_access(4'h7, 32'h8000_0800, 1'b0, 20'h80000);
        drive_access(4'h8, 32'h8000_0800, 1'b1, 20'h7FFFF);
        drive_access(4'h7, 32'h8000_07FF, 1'b1, 20'h00001);
        drive_access(4'hA, 32'h5555_5555, 1'b0, 20'hAAAAA);
        drive_access(4'h5, 32'hAAAA_AAAA, 1'b1, 20'h55555);
        drive_access(4'hA, 32'h5555_5AAA, 1'b1, 20'h0F0F0);
        drive_access(4'h5, 32'hAAAA_A555, 1'b0, 20'hF0F0F);
        drive_access(4'hF, 32'hFFFF_F000, 1'b1, 20'h00000);
        drive_access(4'h0, 32'hFFFF_FFFF, 1'b0, 20'h11111);
        drive_access(4'h3, 32'h1234_5678, 1'b0, 20'h9ABCD);
        drive_access(4'h3, 32'h1234_5FFF, 1'b1, 20'h00000);

        for (int p = 0; p < PHASES; p++) begin
            write_reload(reload_plan[p]);
            build_pools(1 + (p * 5) % 16, 8 + (p * 13) % 41);
            if (p == 2 || p == 5) hold_req++;
            if (p == PHASES - 1) quiet = 1'b1;
            repeat (PHASE_ITEMS) random_access();
        end

        drain_translations();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
